// ===== rtl/cr3_pkg.sv =====
// shared types and constants for the 3x3 cramer solver
`timescale 1ns / 1ps
package cr3_pkg;
	localparam int QB = 33;
	localparam int OUT_W = 32;
	localparam logic [QB-1:0] LIM_POS = 33'h0_7FFF_FFFF;
	localparam logic [QB-1:0] LIM_NEG = 33'h0_8000_0000;

	typedef struct packed {
		logic valid;
		logic sing;
		logic neg;
		logic ovf;
	} dctl_t;
endpackage

// ===== rtl/cr3_det.sv =====
// three-stage determinant pipeline: 2x2 minors, products, sums
`timescale 1ns / 1ps
module cr3_det #(
	parameter int W = 16,
	parameter int DTW = 3 * W + 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [2:0][3:0][W-1:0]        coef,
	output logic                          det_valid,
	output logic [3:0][DTW-1:0]           det
);
	localparam int MW = 2 * W + 1;
	localparam int TW = 3 * W + 1;
	localparam int PA [6] = '{0, 0, 0, 1, 1, 2};
	localparam int PB [6] = '{1, 2, 3, 2, 3, 3};

	logic                 v_s1, v_s2, v_s3;
	logic signed [W-1:0]  a0_s1 [4];
	logic signed [MW-1:0] m_s1 [6];
	logic signed [MW-1:0] mn [6];
	logic signed [TW-1:0] p_s2 [12];
	logic signed [DTW-1:0] d_s3 [4];

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			mn[k] = MW'($signed(coef[1][PA[k]])) * MW'($signed(coef[2][PB[k]]))
				- MW'($signed(coef[1][PB[k]])) * MW'($signed(coef[2][PA[k]]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) a0_s1[c] <= $signed(coef[0][c]);
			for (int k = 0; k < 6; k++) m_s1[k] <= mn[k];
			// minors: 0=01 1=02 2=03 3=12 4=13 5=23
			p_s2[0]  <= TW'(a0_s1[0]) * TW'(m_s1[3]);
			p_s2[1]  <= TW'(a0_s1[1]) * TW'(m_s1[1]);
			p_s2[2]  <= TW'(a0_s1[2]) * TW'(m_s1[0]);
			p_s2[3]  <= TW'(a0_s1[3]) * TW'(m_s1[3]);
			p_s2[4]  <= TW'(a0_s1[1]) * TW'(m_s1[5]);
			p_s2[5]  <= TW'(a0_s1[2]) * TW'(m_s1[4]);
			p_s2[6]  <= TW'(a0_s1[0]) * TW'(m_s1[5]);
			p_s2[7]  <= TW'(a0_s1[3]) * TW'(m_s1[1]);
			p_s2[8]  <= TW'(a0_s1[2]) * TW'(m_s1[2]);
			p_s2[9]  <= TW'(a0_s1[0]) * TW'(m_s1[4]);
			p_s2[10] <= TW'(a0_s1[1]) * TW'(m_s1[2]);
			p_s2[11] <= TW'(a0_s1[3]) * TW'(m_s1[0]);
			d_s3[0] <= DTW'(p_s2[0]) - DTW'(p_s2[1]) + DTW'(p_s2[2]);
			d_s3[1] <= DTW'(p_s2[3]) + DTW'(p_s2[4]) - DTW'(p_s2[5]);
			d_s3[2] <= DTW'(p_s2[8]) - DTW'(p_s2[6]) - DTW'(p_s2[7]);
			d_s3[3] <= DTW'(p_s2[9]) - DTW'(p_s2[10]) + DTW'(p_s2[11]);
		end
	end

	assign det_valid = v_s3;
	always_comb begin
		for (int k = 0; k < 4; k++) det[k] = d_s3[k];
	end
endmodule

// ===== rtl/cr3_div_stage.sv =====
// one restoring division step with its pipeline register
`timescale 1ns / 1ps
module cr3_div_stage #(
	parameter int DW = 52
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  cr3_pkg::dctl_t       ctl_in,
	input  logic [DW-1:0]        rem_in,
	input  logic [DW-1:0]        den_in,
	input  logic [cr3_pkg::QB-1:0] nb_in,
	input  logic [cr3_pkg::QB-1:0] q_in,
	output cr3_pkg::dctl_t       ctl_out,
	output logic [DW-1:0]        rem_out,
	output logic [DW-1:0]        den_out,
	output logic [cr3_pkg::QB-1:0] nb_out,
	output logic [cr3_pkg::QB-1:0] q_out
);
	import cr3_pkg::*;

	logic [DW:0]   t;
	logic          ge;
	dctl_t         ctl_s1;
	logic [DW-1:0] rem_s1, den_s1;
	logic [QB-1:0] nb_s1, q_s1;

	assign t  = {rem_in, nb_in[QB-1]};
	assign ge = t >= {1'b0, den_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= ge ? DW'(t - {1'b0, den_in}) : t[DW-1:0];
			den_s1 <= den_in;
			nb_s1  <= {nb_in[QB-2:0], 1'b0};
			q_s1   <= {q_in[QB-2:0], ge};
		end
	end

	assign ctl_out = ctl_s1;
	assign rem_out = rem_s1;
	assign den_out = den_s1;
	assign nb_out  = nb_s1;
	assign q_out   = q_s1;
endmodule

// ===== rtl/cramer_3x3_solver.sv =====
// top level of the pipelined 3x3 cramer solver
// stages from request accept to result: 3 determinant, 1 setup,
// 33 division steps, 1 output stage
// throughput: one request per cycle; the whole pipeline holds while a result is stalled
// reset: arst_n clears all valid bits asynchronously; data registers are not reset
`timescale 1ns / 1ps
module cramer_3x3_solver #(
	parameter int COEF_WIDTH = 16,
	parameter int RESULT_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [COEF_WIDTH-1:0]  coef_x1,
	input  logic [COEF_WIDTH-1:0]  coef_y1,
	input  logic [COEF_WIDTH-1:0]  coef_z1,
	input  logic [COEF_WIDTH-1:0]  rhs1,
	input  logic [COEF_WIDTH-1:0]  coef_x2,
	input  logic [COEF_WIDTH-1:0]  coef_y2,
	input  logic [COEF_WIDTH-1:0]  coef_z2,
	input  logic [COEF_WIDTH-1:0]  rhs2,
	input  logic [COEF_WIDTH-1:0]  coef_x3,
	input  logic [COEF_WIDTH-1:0]  coef_y3,
	input  logic [COEF_WIDTH-1:0]  coef_z3,
	input  logic [COEF_WIDTH-1:0]  rhs3,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [cr3_pkg::OUT_W-1:0] sol_x,
	output logic signed [cr3_pkg::OUT_W-1:0] sol_y,
	output logic signed [cr3_pkg::OUT_W-1:0] sol_z,
	output logic                   singular,
	output logic                   overflow
);
	import cr3_pkg::*;

	localparam int W   = COEF_WIDTH;
	localparam int F   = RESULT_FRAC_BITS;
	localparam int DTW = 3 * W + 3;
	localparam int DW  = DTW + 1;
	localparam int NW  = DTW + F + 1;

	logic                    en;
	logic [2:0][3:0][W-1:0]  coef;
	logic                    det_valid;
	logic [3:0][DTW-1:0]     det;

	logic [DTW-1:0]          ad;
	logic [DW-1:0]           den;
	logic [NW-1:0]           num [3];
	logic [NW-1:0]           r0 [3];
	logic [DTW-1:0]          an [3];

	dctl_t                   ctl_s4 [3];
	logic [DW-1:0]           rem_s4 [3];
	logic [DW-1:0]           den_s4;
	logic [QB-1:0]           nb_s4 [3];

	dctl_t                   ctl_p [3][QB+1];
	logic [DW-1:0]           rem_p [3][QB+1];
	logic [DW-1:0]           den_p [3][QB+1];
	logic [QB-1:0]           nb_p  [3][QB+1];
	logic [QB-1:0]           q_p   [3][QB+1];

	logic [OUT_W-1:0]        res [3];
	logic [2:0]              sat;

	logic                    ov_q;
	logic [OUT_W-1:0]        sx_q, sy_q, sz_q;
	logic                    sing_q, ovf_q;

	assign en       = !(ov_q && out_stall);
	assign in_stall = ov_q && out_stall;

	assign coef[0] = {rhs1, coef_z1, coef_y1, coef_x1};
	assign coef[1] = {rhs2, coef_z2, coef_y2, coef_x2};
	assign coef[2] = {rhs3, coef_z3, coef_y3, coef_x3};

	cr3_det #(.W(W), .DTW(DTW)) u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.coef      (coef),
		.det_valid (det_valid),
		.det       (det)
	);

	// setup: magnitudes, signs, scaled numerators
	always_comb begin
		ad  = det[0][DTW-1] ? DTW'(-det[0]) : det[0];
		den = {ad, 1'b0};
		for (int l = 0; l < 3; l++) begin
			an[l]  = det[l+1][DTW-1] ? DTW'(-det[l+1]) : det[l+1];
			num[l] = (NW'(an[l]) << (F + 1)) + NW'(ad);
			r0[l]  = num[l] >> QB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < 3; l++) ctl_s4[l] <= '0;
		end else if (en) begin
			for (int l = 0; l < 3; l++) begin
				ctl_s4[l].valid <= det_valid;
				ctl_s4[l].sing  <= (det[0] == '0);
				ctl_s4[l].neg   <= det[l+1][DTW-1] ^ det[0][DTW-1];
				ctl_s4[l].ovf   <= (r0[l] >= NW'(den));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s4 <= den;
			for (int l = 0; l < 3; l++) begin
				rem_s4[l] <= r0[l][DW-1:0];
				nb_s4[l]  <= num[l][QB-1:0];
			end
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		assign ctl_p[l][0] = ctl_s4[l];
		assign rem_p[l][0] = rem_s4[l];
		assign den_p[l][0] = den_s4;
		assign nb_p[l][0]  = nb_s4[l];
		assign q_p[l][0]   = '0;

		for (genvar i = 0; i < QB; i++) begin : g_step
			cr3_div_stage #(.DW(DW)) u_step (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.ctl_in  (ctl_p[l][i]),
				.rem_in  (rem_p[l][i]),
				.den_in  (den_p[l][i]),
				.nb_in   (nb_p[l][i]),
				.q_in    (q_p[l][i]),
				.ctl_out (ctl_p[l][i+1]),
				.rem_out (rem_p[l][i+1]),
				.den_out (den_p[l][i+1]),
				.nb_out  (nb_p[l][i+1]),
				.q_out   (q_p[l][i+1])
			);
		end
	end

	// saturation and sign
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			logic [QB-1:0] lim;
			logic [QB-1:0] qs;
			lim    = ctl_p[l][QB].neg ? LIM_NEG : LIM_POS;
			sat[l] = ctl_p[l][QB].ovf || (q_p[l][QB] > lim);
			qs     = sat[l] ? lim : q_p[l][QB];
			res[l] = ctl_p[l][QB].neg ? OUT_W'(-qs[OUT_W-1:0]) : qs[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= ctl_p[0][QB].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_p[0][QB].sing) begin
				sx_q  <= '0;
				sy_q  <= '0;
				sz_q  <= '0;
				ovf_q <= 1'b0;
			end else begin
				sx_q  <= res[0];
				sy_q  <= res[1];
				sz_q  <= res[2];
				ovf_q <= |sat;
			end
			sing_q <= ctl_p[0][QB].sing;
		end
	end

	assign out_valid = ov_q;
	assign sol_x     = $signed(sx_q);
	assign sol_y     = $signed(sy_q);
	assign sol_z     = $signed(sz_q);
	assign singular  = sing_q;
	assign overflow  = ovf_q;

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> sol_x == '0 && sol_y == '0 && sol_z == '0 && !overflow)
		else $error("singular result with nonzero payload");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sol_x) && $stable(singular))
		else $error("stalled result lost or changed");
endmodule
